// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define BWST_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("bwst assertion failed");

// Checks that a condition is followed by another in the next cycle.
`define BWST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bwst assertion failed");

`endif

// File: hw/rtl/bwst_pkg.sv
package bwst_pkg;

	localparam int TIMER_W = 24;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	localparam logic [1:0] PH_ACQ  = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_SCAN = 2'd2;

	localparam logic [2:0] REG_INTERVAL = 3'd0;
	localparam logic [2:0] REG_GUARD    = 3'd1;
	localparam logic [2:0] REG_MISSES   = 3'd2;
	localparam logic [2:0] REG_MAGIC0   = 3'd3;
	localparam logic [2:0] REG_MAGIC1   = 3'd4;

	localparam logic [TIMER_W-1:0] INTERVAL_RST = TIMER_W'(900000);
	localparam logic [TIMER_W-1:0] GUARD_RST    = TIMER_W'(60000);
	localparam logic [3:0]         MISSES_RST   = 4'd3;
	localparam logic [7:0]         MAGIC0_RST   = 8'h88;
	localparam logic [7:0]         MAGIC1_RST   = 8'h77;

	localparam logic [4:0] PKT_LEN   = 5'd6;
	localparam logic [3:0] MISS_SAT  = 4'd15;
	localparam logic       OP_TICK   = 1'b0;

	typedef struct packed {
		logic       opcode;
		logic       mfr_present;
		logic [4:0] mfr_length;
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
		logic [7:0] byte_four;
		logic [7:0] byte_five;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic               scan_enable;
		logic               in_sync;
		logic [3:0]         misses;
		logic [15:0]        beacon_id;
		logic signed [15:0] temperature;
		logic               accepted;
		logic               display_update;
	} out_item_t;

endpackage

// File: hw/rtl/bwst_if.sv
interface bwst_in_if;
	logic               valid;
	logic               ready;
	bwst_pkg::in_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface bwst_out_if;
	logic                valid;
	logic                ready;
	bwst_pkg::out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: hw/rtl/beacon_window_sync_tracker_unit.sv
// Channel   Role     Carries
// events    sink     one tick or one advertisement per item
// status    source   phase, flags, miss count and held sensor data per item
// apb       slave    five configuration registers at byte addresses 0 to 16
//
// An input register feeds one compare-and-update step, whose result is registered;
// a new item is accepted every cycle while status is not stalled.
// The result register frees the input side whenever the result is taken or empty.
// Reset clears the valid flags and tracker state and loads the register defaults.
// A stall on status holds the result and, once the input register is full, events.
module beacon_window_sync_tracker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	bwst_in_if.sink                       events,
	bwst_out_if.source                    status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bwst_pkg::APB_AW-1:0]   paddr,
	input  logic [bwst_pkg::APB_DW-1:0]   pwdata,
	output logic [bwst_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int TW = bwst_pkg::TIMER_W;

	logic [TW-1:0] interval_q;
	logic [TW-1:0] guard_q;
	logic [3:0]    max_misses_q;
	logic [7:0]    magic0_q;
	logic [7:0]    magic1_q;

	logic [2:0] reg_idx;
	logic       cfg_wr;

	logic               valid_s1;
	bwst_pkg::in_item_t item_s1;
	logic               advance;

	logic               out_valid_q;
	bwst_pkg::out_item_t out_item_q;

	logic [1:0]         phase_q;
	logic               sync_q;
	logic               scan_q;
	logic               seen_q;
	logic [3:0]         miss_q;
	logic [15:0]        id_q;
	logic signed [15:0] temp_q;
	logic [TW-1:0]      since_q;
	logic [TW-1:0]      window_q;

	logic [1:0]         phase_d;
	logic               sync_d;
	logic               scan_d;
	logic               seen_d;
	logic [3:0]         miss_d;
	logic [15:0]        id_d;
	logic signed [15:0] temp_d;
	logic [TW-1:0]      since_d;
	logic [TW-1:0]      window_d;
	logic               accepted_d;
	logic               refresh_d;

	logic [TW-1:0] since_inc;
	logic [TW-1:0] window_inc;
	logic [TW-1:0] wake;
	logic [3:0]    miss_inc;
	logic          pkt_ok;

	assign reg_idx = paddr[bwst_pkg::APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q   <= bwst_pkg::INTERVAL_RST;
			guard_q      <= bwst_pkg::GUARD_RST;
			max_misses_q <= bwst_pkg::MISSES_RST;
			magic0_q     <= bwst_pkg::MAGIC0_RST;
			magic1_q     <= bwst_pkg::MAGIC1_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				bwst_pkg::REG_INTERVAL: interval_q   <= pwdata[TW-1:0];
				bwst_pkg::REG_GUARD:    guard_q      <= pwdata[TW-1:0];
				bwst_pkg::REG_MISSES:   max_misses_q <= pwdata[3:0];
				bwst_pkg::REG_MAGIC0:   magic0_q     <= pwdata[7:0];
				bwst_pkg::REG_MAGIC1:   magic1_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bwst_pkg::REG_INTERVAL: prdata = bwst_pkg::APB_DW'(interval_q);
			bwst_pkg::REG_GUARD:    prdata = bwst_pkg::APB_DW'(guard_q);
			bwst_pkg::REG_MISSES:   prdata = bwst_pkg::APB_DW'(max_misses_q);
			bwst_pkg::REG_MAGIC0:   prdata = bwst_pkg::APB_DW'(magic0_q);
			bwst_pkg::REG_MAGIC1:   prdata = bwst_pkg::APB_DW'(magic1_q);
			default:                prdata = '0;
		endcase
	end

	assign advance      = valid_s1 && (!out_valid_q || status.ready);
	assign events.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			item_s1 <= events.payload;
		end
	end

	assign since_inc  = (since_q == '1) ? since_q : since_q + 1'b1;
	assign window_inc = (window_q == '1) ? window_q : window_q + 1'b1;
	assign wake       = (guard_q >= interval_q) ? '0 : interval_q - guard_q;
	assign miss_inc   = (miss_q < bwst_pkg::MISS_SAT) ? miss_q + 1'b1 : miss_q;
	assign pkt_ok     = item_s1.mfr_present && (item_s1.mfr_length == bwst_pkg::PKT_LEN) &&
		(item_s1.byte_zero == magic0_q) && (item_s1.byte_one == magic1_q);

	always_comb begin
		phase_d    = phase_q;
		sync_d     = sync_q;
		scan_d     = scan_q;
		seen_d     = seen_q;
		miss_d     = miss_q;
		id_d       = id_q;
		temp_d     = temp_q;
		since_d    = since_q;
		window_d   = window_q;
		accepted_d = 1'b0;
		refresh_d  = 1'b0;
		if (item_s1.opcode == bwst_pkg::OP_TICK) begin
			case (phase_q)
				bwst_pkg::PH_WAIT: begin
					scan_d = 1'b0;
					if (!sync_q) begin
						phase_d = bwst_pkg::PH_ACQ;
					end else begin
						since_d = since_inc;
						if (since_inc >= wake) begin
							phase_d   = bwst_pkg::PH_SCAN;
							seen_d    = 1'b0;
							window_d  = '0;
							scan_d    = 1'b1;
							refresh_d = 1'b1;
						end
					end
				end
				bwst_pkg::PH_SCAN: begin
					scan_d   = 1'b1;
					window_d = window_inc;
					if (window_inc >= guard_q) begin
						scan_d    = 1'b0;
						refresh_d = 1'b1;
						phase_d   = bwst_pkg::PH_WAIT;
						if (seen_q) begin
							miss_d = '0;
						end else if (miss_inc >= max_misses_q) begin
							phase_d = bwst_pkg::PH_ACQ;
							sync_d  = 1'b0;
							miss_d  = '0;
						end else begin
							miss_d = miss_inc;
						end
					end
				end
				default: begin
					phase_d = bwst_pkg::PH_ACQ;
					scan_d  = 1'b1;
					since_d = since_inc;
				end
			endcase
		end else if (pkt_ok) begin
			accepted_d = 1'b1;
			refresh_d  = 1'b1;
			sync_d     = 1'b1;
			id_d       = {item_s1.byte_two, item_s1.byte_three};
			temp_d     = signed'({item_s1.byte_four, item_s1.byte_five});
			since_d    = '0;
			miss_d     = '0;
			if (phase_q == bwst_pkg::PH_SCAN) begin
				seen_d = 1'b1;
			end
			phase_d = bwst_pkg::PH_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bwst_pkg::PH_ACQ;
			sync_q   <= 1'b0;
			scan_q   <= 1'b0;
			seen_q   <= 1'b0;
			miss_q   <= '0;
			id_q     <= '0;
			temp_q   <= '0;
			since_q  <= '0;
			window_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			sync_q   <= sync_d;
			scan_q   <= scan_d;
			seen_q   <= seen_d;
			miss_q   <= miss_d;
			id_q     <= id_d;
			temp_q   <= temp_d;
			since_q  <= since_d;
			window_q <= window_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.phase          <= phase_d;
			out_item_q.scan_enable    <= scan_d;
			out_item_q.in_sync        <= sync_d;
			out_item_q.misses         <= miss_d;
			out_item_q.beacon_id      <= id_d;
			out_item_q.temperature    <= temp_d;
			out_item_q.accepted       <= accepted_d;
			out_item_q.display_update <= refresh_d;
		end
	end

	assign status.valid   = out_valid_q;
	assign status.payload = out_item_q;

endmodule

// File: hw/rtl/bwst_checker.sv
`include "assert_macros.svh"

module bwst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  phase,
	input logic        scan_enable,
	input logic        in_sync,
	input logic [3:0]  misses,
	input logic        accepted,
	input logic        display_update
);

	logic accept_ok;
	logic scan_ok;
	logic idle_ok;

	assign accept_ok = !(out_valid && accepted) ||
		(phase == bwst_pkg::PH_WAIT && in_sync && misses == 4'd0 && display_update);
	assign scan_ok   = !(out_valid && phase == bwst_pkg::PH_SCAN) || scan_enable;
	assign idle_ok   = !(out_valid && !in_sync) ||
		(phase == bwst_pkg::PH_ACQ && misses == 4'd0);

	`BWST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`BWST_ASSERT(a_accept_locks, clk, arst_n, accept_ok)
	`BWST_ASSERT(a_scan_on, clk, arst_n, scan_ok)
	`BWST_ASSERT(a_unlocked_idle, clk, arst_n, idle_ok)

endmodule

bind beacon_window_sync_tracker_unit bwst_checker u_bwst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (status.valid),
	.out_ready      (status.ready),
	.phase          (status.payload.phase),
	.scan_enable    (status.payload.scan_enable),
	.in_sync        (status.payload.in_sync),
	.misses         (status.payload.misses),
	.accepted       (status.payload.accepted),
	.display_update (status.payload.display_update)
);
